// ===== rtl/trapezoidal_profile_generator_top_defines.svh =====
// assertion macros for the profile generator top level
`ifndef TRAPEZOIDAL_PROFILE_GENERATOR_TOP_DEFINES_SVH
`define TRAPEZOIDAL_PROFILE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TPG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpg: assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TPG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpg: assertion failed");

`endif

// ===== rtl/tpg_pkg.sv =====
// types and constants of the trapezoidal profile generator
`default_nettype none

package tpg_pkg;

  // restoring divider steps per quotient and square root steps per root
  localparam int unsigned DivSteps  = 52;
  localparam int unsigned SqrtSteps = 26;
  // input register, divider, square root and six arithmetic stages
  localparam int unsigned Latency   = 1 + DivSteps + SqrtSteps + 6;

  // register reset values
  localparam logic [23:0] VelReset = 24'd65536;
  localparam logic [23:0] AccReset = 24'd131072;

  // configuration register indexes
  typedef enum logic {
    REG_MAX_VEL = 1'b0,
    REG_MAX_ACC = 1'b1
  } reg_idx_e;

  // sequencer that derives the rate constants after reset or a write
  typedef enum logic [1:0] {
    CS_SQUARE,
    CS_T1,
    CS_DFS,
    CS_IDLE
  } cfg_state_e;

  // profile segment of one sample
  typedef enum logic [1:0] {
    SEG_ACC,
    SEG_CRUISE,
    SEG_TDEC,
    SEG_QDEC
  } seg_e;

  // rates and derived constants handed to the datapath
  typedef struct packed {
    logic [23:0] vel;
    logic [23:0] acc;
    logic [52:0] vv16;
    logic [39:0] t1;
    logic [23:0] dfs;
  } tpg_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/tpg_pipe.sv =====
// pipelined datapath: dividers, square root and profile arithmetic
`default_nettype none

module tpg_pipe (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic signed [23:0]     target_move_i,
  input  wire logic        [23:0]     elapsed_time_i,
  input  wire tpg_pkg::tpg_cfg_t      cfg_i,
  output logic                        out_valid_o,
  output logic signed [23:0]          ref_position_o,
  output logic signed [23:0]          ref_velocity_o
);

  localparam int unsigned NDiv = tpg_pkg::DivSteps;
  localparam int unsigned NSq  = tpg_pkg::SqrtSteps;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [24:0] div_step(input logic [23:0] rem, input logic nb,
                                           input logic [23:0] dsr);
    logic [24:0] rt;
    logic [24:0] df;
    rt = {rem, nb};
    df = rt - {1'b0, dsr};
    if (rt >= {1'b0, dsr}) begin
      return {1'b1, df[23:0]};
    end
    return {1'b0, rt[23:0]};
  endfunction

  // magnitude and sign to a saturated 24-bit field
  function automatic logic [23:0] sat24(input logic neg, input logic [31:0] mag);
    logic [23:0] r;
    if (neg) begin
      if (mag >= 32'h0080_0000) r = 24'h80_0000;
      else r = 24'd0 - mag[23:0];
    end else begin
      if (mag > 32'h007F_FFFF) r = 24'h7F_FFFF;
      else r = mag[23:0];
    end
    return r;
  endfunction

  // input stage: magnitude, time and the triangle test product
  logic        s0_v_q;
  logic [23:0] s0_d_q, s0_t_q;
  logic        s0_neg_q;
  logic [47:0] s0_da_q;
  logic        in_neg;
  logic [23:0] in_mag;

  assign in_neg = target_move_i[23];
  assign in_mag = in_neg ? (24'd0 - $unsigned(target_move_i)) : $unsigned(target_move_i);

  // divider stages: D*2^28/A and D*2^12/V, one quotient bit a stage
  logic        dv_v_q   [NDiv];
  logic        dv_v_d   [NDiv];
  logic [23:0] dv_d_q   [NDiv];
  logic [23:0] dv_d_d   [NDiv];
  logic [23:0] dv_t_q   [NDiv];
  logic [23:0] dv_t_d   [NDiv];
  logic        dv_neg_q [NDiv];
  logic        dv_neg_d [NDiv];
  logic        dv_tri_q [NDiv];
  logic        dv_tri_d [NDiv];
  logic [23:0] dv_r1_q  [NDiv];
  logic [23:0] dv_r1_d  [NDiv];
  logic [51:0] dv_q1_q  [NDiv];
  logic [51:0] dv_q1_d  [NDiv];
  logic [23:0] dv_r2_q  [NDiv];
  logic [23:0] dv_r2_d  [NDiv];
  logic [51:0] dv_q2_q  [NDiv];
  logic [51:0] dv_q2_d  [NDiv];

  always_comb begin
    logic        pv, pneg, ptri;
    logic [23:0] pd, pt, pr1, pr2;
    logic [51:0] pq1, pq2, n1, n2;
    logic [24:0] s1, s2;
    for (int k = 0; k < NDiv; k++) begin
      if (k == 0) begin
        pv   = s0_v_q;
        pd   = s0_d_q;
        pt   = s0_t_q;
        pneg = s0_neg_q;
        ptri = ({5'd0, s0_da_q} < cfg_i.vv16);
        pr1  = '0;
        pr2  = '0;
        pq1  = '0;
        pq2  = '0;
      end else begin
        pv   = dv_v_q[k-1];
        pd   = dv_d_q[k-1];
        pt   = dv_t_q[k-1];
        pneg = dv_neg_q[k-1];
        ptri = dv_tri_q[k-1];
        pr1  = dv_r1_q[k-1];
        pr2  = dv_r2_q[k-1];
        pq1  = dv_q1_q[k-1];
        pq2  = dv_q2_q[k-1];
      end
      n1 = {pd, 28'd0};
      n2 = {16'd0, pd, 12'd0};
      s1 = div_step(pr1, n1[NDiv-1-k], cfg_i.acc);
      s2 = div_step(pr2, n2[NDiv-1-k], cfg_i.vel);
      dv_v_d[k]   = pv;
      dv_d_d[k]   = pd;
      dv_t_d[k]   = pt;
      dv_neg_d[k] = pneg;
      dv_tri_d[k] = ptri;
      dv_r1_d[k]  = s1[23:0];
      dv_q1_d[k]  = {pq1[50:0], s1[24]};
      dv_r2_d[k]  = s2[23:0];
      dv_q2_d[k]  = {pq2[50:0], s2[24]};
    end
  end

  // square root stages: one root bit a stage from a bit pair of the quotient
  logic        sq_v_q    [NSq];
  logic        sq_v_d    [NSq];
  logic [23:0] sq_d_q    [NSq];
  logic [23:0] sq_d_d    [NSq];
  logic [23:0] sq_t_q    [NSq];
  logic [23:0] sq_t_d    [NSq];
  logic        sq_neg_q  [NSq];
  logic        sq_neg_d  [NSq];
  logic        sq_tri_q  [NSq];
  logic        sq_tri_d  [NSq];
  logic [35:0] sq_tc_q   [NSq];
  logic [35:0] sq_tc_d   [NSq];
  logic [51:0] sq_x_q    [NSq];
  logic [51:0] sq_x_d    [NSq];
  logic [26:0] sq_rem_q  [NSq];
  logic [26:0] sq_rem_d  [NSq];
  logic [25:0] sq_root_q [NSq];
  logic [25:0] sq_root_d [NSq];

  always_comb begin
    logic        pv, pneg, ptri;
    logic [23:0] pd, pt;
    logic [35:0] ptc;
    logic [51:0] px;
    logic [26:0] prem;
    logic [25:0] proot;
    logic [28:0] rt, trial, df;
    logic        ge;
    for (int j = 0; j < NSq; j++) begin
      if (j == 0) begin
        pv    = dv_v_q[NDiv-1];
        pd    = dv_d_q[NDiv-1];
        pt    = dv_t_q[NDiv-1];
        pneg  = dv_neg_q[NDiv-1];
        ptri  = dv_tri_q[NDiv-1];
        ptc   = dv_q2_q[NDiv-1][35:0];
        px    = dv_q1_q[NDiv-1];
        prem  = '0;
        proot = '0;
      end else begin
        pv    = sq_v_q[j-1];
        pd    = sq_d_q[j-1];
        pt    = sq_t_q[j-1];
        pneg  = sq_neg_q[j-1];
        ptri  = sq_tri_q[j-1];
        ptc   = sq_tc_q[j-1];
        px    = sq_x_q[j-1];
        prem  = sq_rem_q[j-1];
        proot = sq_root_q[j-1];
      end
      rt    = {prem, px[51-2*j -: 2]};
      trial = {1'b0, proot, 2'b01};
      df    = rt - trial;
      ge    = (rt >= trial);
      sq_v_d[j]    = pv;
      sq_d_d[j]    = pd;
      sq_t_d[j]    = pt;
      sq_neg_d[j]  = pneg;
      sq_tri_d[j]  = ptri;
      sq_tc_d[j]   = ptc;
      sq_x_d[j]    = px;
      sq_rem_d[j]  = ge ? df[26:0] : rt[26:0];
      sq_root_d[j] = {proot[24:0], ge};
    end
  end

  // r0: pick the profile segment and the time offset within it
  logic               r0_v_q, r0_stop_q, r0_stop_d, r0_neg_q;
  tpg_pkg::seg_e      r0_seg_q, r0_seg_d;
  logic [23:0]        r0_u_q, r0_u_d, r0_ts_q, r0_d_q;

  always_comb begin
    logic [23:0] t;
    logic [25:0] ts;
    logic [35:0] tc;
    t  = sq_t_q[NSq-1];
    ts = sq_root_q[NSq-1];
    tc = sq_tc_q[NSq-1];
    r0_seg_d  = tpg_pkg::SEG_ACC;
    r0_u_d    = t;
    r0_stop_d = 1'b0;
    if (sq_tri_q[NSq-1]) begin
      if ({2'd0, t} >= ts) begin
        r0_seg_d  = tpg_pkg::SEG_TDEC;
        r0_u_d    = t - ts[23:0];
        r0_stop_d = (r0_u_d > ts[23:0]);
      end
    end else if ({16'd0, t} >= cfg_i.t1) begin
      if ({12'd0, t} < tc) begin
        r0_seg_d = tpg_pkg::SEG_CRUISE;
        r0_u_d   = t - cfg_i.t1[23:0];
      end else begin
        r0_seg_d = tpg_pkg::SEG_QDEC;
        r0_u_d   = t - tc[23:0];
      end
    end
  end

  // r1: rate products
  logic          r1_v_q, r1_stop_q, r1_neg_q;
  tpg_pkg::seg_e r1_seg_q;
  logic [23:0]   r1_u_q, r1_ts_q, r1_d_q;
  logic [47:0]   r1_pa_q, r1_pv_q, r1_pw_q;
  logic [23:0]   r0_tsu;

  assign r0_tsu = r0_ts_q - r0_u_q;

  // r2: operands of the position product, velocity and offset
  logic        r2_v_q, r2_stop_q, r2_neg_q, r2_stop_d;
  logic [47:0] r2_x_q, r2_x_d;
  logic [24:0] r2_y_q, r2_y_d;
  logic [31:0] r2_vr_q, r2_vr_d;
  logic [23:0] r2_off_q, r2_off_d, r2_d_q;

  always_comb begin
    logic [47:0] vs, vdiff;
    vs    = {8'd0, cfg_i.vel, 16'd0};
    vdiff = vs - r1_pa_q;
    r2_stop_d = r1_stop_q;
    case (r1_seg_q)
      tpg_pkg::SEG_ACC: begin
        r2_x_d   = r1_pa_q;
        r2_y_d   = {1'b0, r1_u_q};
        r2_vr_d  = r1_pa_q[47:16];
        r2_off_d = '0;
      end
      tpg_pkg::SEG_CRUISE: begin
        r2_x_d   = r1_pv_q;
        r2_y_d   = 25'h002_0000;
        r2_vr_d  = {8'd0, cfg_i.vel};
        r2_off_d = cfg_i.dfs;
      end
      tpg_pkg::SEG_TDEC: begin
        r2_x_d   = r1_pa_q;
        r2_y_d   = {r1_ts_q, 1'b0} - {1'b0, r1_u_q};
        r2_vr_d  = r1_pw_q[47:16];
        r2_off_d = {1'b0, r1_d_q[23:1]};
      end
      default: begin
        r2_x_d    = {7'd0, cfg_i.vel, 17'd0} - r1_pa_q;
        r2_y_d    = {1'b0, r1_u_q};
        r2_vr_d   = {8'd0, vdiff[39:16]};
        r2_off_d  = r1_d_q - cfg_i.dfs;
        r2_stop_d = r1_stop_q || (r1_pa_q > vs);
      end
    endcase
  end

  // r3: split position product, r4: sum and scale
  logic        r3_v_q, r3_stop_q, r3_neg_q;
  logic [48:0] r3_pl_q, r3_ph_q;
  logic [31:0] r3_vr_q;
  logic [23:0] r3_off_q, r3_d_q;
  logic        r4_v_q, r4_stop_q, r4_neg_q;
  logic [43:0] r4_q_q;
  logic [31:0] r4_vr_q;
  logic [23:0] r4_off_q, r4_d_q;
  logic [72:0] r3_sum;

  assign r3_sum = {r3_ph_q, 24'd0} + {24'd0, r3_pl_q};

  // r5: offset, end clamp, sign and saturation
  logic        r4_clamp;
  logic [44:0] r4_psum;
  logic [23:0] r4_pm;
  logic [31:0] r4_vm;

  assign r4_psum  = {1'b0, r4_q_q} + {21'd0, r4_off_q};
  assign r4_clamp = r4_stop_q || (r4_psum > {21'd0, r4_d_q});
  assign r4_pm    = r4_clamp ? r4_d_q : r4_psum[23:0];
  assign r4_vm    = r4_clamp ? 32'd0 : r4_vr_q;

  logic        o_v_q;
  logic [23:0] o_pos_q, o_vel_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      for (int k = 0; k < NDiv; k++) dv_v_q[k] <= 1'b0;
      for (int j = 0; j < NSq; j++) sq_v_q[j] <= 1'b0;
      r0_v_q <= 1'b0;
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
      r4_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      s0_v_q <= in_valid_i;
      for (int k = 0; k < NDiv; k++) dv_v_q[k] <= dv_v_d[k];
      for (int j = 0; j < NSq; j++) sq_v_q[j] <= sq_v_d[j];
      r0_v_q <= sq_v_q[NSq-1];
      r1_v_q <= r0_v_q;
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
      r4_v_q <= r3_v_q;
      o_v_q  <= r4_v_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s0_d_q   <= in_mag;
    s0_t_q   <= elapsed_time_i;
    s0_neg_q <= in_neg;
    s0_da_q  <= 48'(in_mag) * 48'(cfg_i.acc);
    for (int k = 0; k < NDiv; k++) begin
      dv_d_q[k]   <= dv_d_d[k];
      dv_t_q[k]   <= dv_t_d[k];
      dv_neg_q[k] <= dv_neg_d[k];
      dv_tri_q[k] <= dv_tri_d[k];
      dv_r1_q[k]  <= dv_r1_d[k];
      dv_q1_q[k]  <= dv_q1_d[k];
      dv_r2_q[k]  <= dv_r2_d[k];
      dv_q2_q[k]  <= dv_q2_d[k];
    end
    for (int j = 0; j < NSq; j++) begin
      sq_d_q[j]    <= sq_d_d[j];
      sq_t_q[j]    <= sq_t_d[j];
      sq_neg_q[j]  <= sq_neg_d[j];
      sq_tri_q[j]  <= sq_tri_d[j];
      sq_tc_q[j]   <= sq_tc_d[j];
      sq_x_q[j]    <= sq_x_d[j];
      sq_rem_q[j]  <= sq_rem_d[j];
      sq_root_q[j] <= sq_root_d[j];
    end
    r0_seg_q  <= r0_seg_d;
    r0_stop_q <= r0_stop_d;
    r0_u_q    <= r0_u_d;
    r0_ts_q   <= sq_root_q[NSq-1][23:0];
    r0_d_q    <= sq_d_q[NSq-1];
    r0_neg_q  <= sq_neg_q[NSq-1];
    r1_seg_q  <= r0_seg_q;
    r1_stop_q <= r0_stop_q;
    r1_u_q    <= r0_u_q;
    r1_ts_q   <= r0_ts_q;
    r1_d_q    <= r0_d_q;
    r1_neg_q  <= r0_neg_q;
    r1_pa_q   <= 48'(cfg_i.acc) * 48'(r0_u_q);
    r1_pv_q   <= 48'(cfg_i.vel) * 48'(r0_u_q);
    r1_pw_q   <= 48'(cfg_i.acc) * 48'(r0_tsu);
    r2_x_q    <= r2_x_d;
    r2_y_q    <= r2_y_d;
    r2_vr_q   <= r2_vr_d;
    r2_off_q  <= r2_off_d;
    r2_stop_q <= r2_stop_d;
    r2_d_q    <= r1_d_q;
    r2_neg_q  <= r1_neg_q;
    r3_pl_q   <= 49'(r2_x_q[23:0]) * 49'(r2_y_q);
    r3_ph_q   <= 49'(r2_x_q[47:24]) * 49'(r2_y_q);
    r3_vr_q   <= r2_vr_q;
    r3_off_q  <= r2_off_q;
    r3_stop_q <= r2_stop_q;
    r3_d_q    <= r2_d_q;
    r3_neg_q  <= r2_neg_q;
    r4_q_q    <= r3_sum[72:29];
    r4_vr_q   <= r3_vr_q;
    r4_off_q  <= r3_off_q;
    r4_stop_q <= r3_stop_q;
    r4_d_q    <= r3_d_q;
    r4_neg_q  <= r3_neg_q;
    o_pos_q   <= sat24(r4_neg_q, {8'd0, r4_pm});
    o_vel_q   <= sat24(r4_neg_q, r4_vm);
  end

  assign out_valid_o    = o_v_q;
  assign ref_position_o = $signed(o_pos_q);
  assign ref_velocity_o = $signed(o_vel_q);

endmodule

`default_nettype wire

// ===== rtl/trapezoidal_profile_generator_top.sv =====
// top level: rate registers, constant sequencer and the profile datapath
`default_nettype none

`include "trapezoidal_profile_generator_top_defines.svh"

// Trapezoidal velocity profile generator. A sample (signed move, elapsed time)
// is taken on any clock where start is high and busy is low, one per cycle if
// wanted; its reference position and velocity appear for one cycle with
// out_valid_o, in the order the samples went in, after passing the input
// register, 52 divider stages, 26 square root stages and the multiply and
// clamp stages. Results cannot be held off, so the receiver must take each
// word on the cycle it appears. After reset and after every register write,
// busy stays high while the time to full speed and the ramp distance are
// divided out one bit a cycle; a zero rate register acts as one.
module trapezoidal_profile_generator_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [23:0] target_move_i,
  input  wire logic        [23:0] elapsed_time_i,
  output logic                    out_valid_o,
  output logic signed [23:0]      ref_position_o,
  output logic signed [23:0]      ref_velocity_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic        [23:0] cfg_wdata_i
);

  localparam logic [5:0] LastStep = 6'(tpg_pkg::DivSteps - 1);

  logic [23:0]             vel_q, acc_q, wr_eff;
  tpg_pkg::cfg_state_e     state_q, state_d;
  logic [5:0]              cnt_q;
  logic [23:0]             rem_q;
  logic [51:0]             num_q, quo_q, quo_n;
  logic [52:0]             vv16_q;
  logic [39:0]             t1_q;
  logic [23:0]             dfs_q;
  logic [24:0]             step;
  logic                    do_square, do_step, last;
  tpg_pkg::tpg_cfg_t       cfg;

  // a zero rate behaves as one
  assign wr_eff = (cfg_wdata_i == 24'd0) ? 24'd1 : cfg_wdata_i;

  // rate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= tpg_pkg::VelReset;
      acc_q <= tpg_pkg::AccReset;
    end else if (cfg_we_i) begin
      unique case (tpg_pkg::reg_idx_e'(cfg_idx_i))
        tpg_pkg::REG_MAX_VEL: vel_q <= wr_eff;
        tpg_pkg::REG_MAX_ACC: acc_q <= wr_eff;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpg_pkg::CS_SQUARE: state_d = tpg_pkg::CS_T1;
      tpg_pkg::CS_T1:     if (last) state_d = tpg_pkg::CS_DFS;
      tpg_pkg::CS_DFS:    if (last) state_d = tpg_pkg::CS_IDLE;
      tpg_pkg::CS_IDLE:   state_d = tpg_pkg::CS_IDLE;
    endcase
    if (cfg_we_i) state_d = tpg_pkg::CS_SQUARE;
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    do_square = 1'b0;
    do_step   = 1'b0;
    unique case (state_q)
      tpg_pkg::CS_SQUARE: do_square = 1'b1;
      tpg_pkg::CS_T1:     do_step = 1'b1;
      tpg_pkg::CS_DFS:    do_step = 1'b1;
      tpg_pkg::CS_IDLE:   busy = 1'b0;
    endcase
  end

  assign last  = (cnt_q == LastStep);
  assign step  = {rem_q, num_q[51]} >= {1'b0, acc_q}
               ? {1'b1, 24'({rem_q, num_q[51]} - {1'b0, acc_q})}
               : {1'b0, rem_q[22:0], num_q[51]};
  assign quo_n = {quo_q[50:0], step[24]};

  // sequencer state and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpg_pkg::CS_SQUARE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (do_square || last) cnt_q <= '0;
      else if (do_step) cnt_q <= cnt_q + 6'd1;
    end
  end

  // shared divider: V*2^16/A, then 8*V*V/A
  always_ff @(posedge clk_i) begin
    if (do_square) begin
      vv16_q <= {1'b0, 48'(vel_q) * 48'(vel_q), 4'd0};
      num_q  <= {12'd0, vel_q, 16'd0};
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (do_step) begin
      if (last) begin
        num_q <= vv16_q[52:1];
        rem_q <= '0;
        quo_q <= '0;
        if (state_q == tpg_pkg::CS_T1) t1_q <= quo_n[39:0];
        else dfs_q <= quo_n[23:0];
      end else begin
        num_q <= {num_q[50:0], 1'b0};
        rem_q <= step[23:0];
        quo_q <= quo_n;
      end
    end
  end

  always_comb begin
    cfg.vel  = vel_q;
    cfg.acc  = acc_q;
    cfg.vv16 = vv16_q;
    cfg.t1   = t1_q;
    cfg.dfs  = dfs_q;
  end

  tpg_pipe u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (start && !busy),
    .target_move_i  (target_move_i),
    .elapsed_time_i (elapsed_time_i),
    .cfg_i          (cfg),
    .out_valid_o    (out_valid_o),
    .ref_position_o (ref_position_o),
    .ref_velocity_o (ref_velocity_o)
  );

  // a write always restarts the constant sequencer
  `TPG_ASSERT_NXT(a_write_busy, cfg_we_i, busy)
  // busy only rises on a write
  `TPG_ASSERT_NXT(a_idle_holds, !busy && !cfg_we_i, !busy)
  // every result word stems from a sample taken one latency earlier
  `TPG_ASSERT_IMP(a_latency, out_valid_o, $past(start && !busy, tpg_pkg::Latency))
  // position and velocity never point in opposite directions
  `TPG_ASSERT_IMP(a_sign, out_valid_o,
    !((ref_position_o[23] && ref_velocity_o != 24'd0 && !ref_velocity_o[23]) ||
      (!ref_position_o[23] && ref_position_o != 24'd0 && ref_velocity_o[23])))

endmodule

`default_nettype wire

// ===== tb/trapezoidal_profile_generator_top_tb.sv =====
// self-checking testbench for the trapezoidal profile generator top level
`timescale 1ns / 100ps
`default_nettype none

module trapezoidal_profile_generator_top_tb;

  typedef struct {
    logic signed [23:0] move;
    logic        [23:0] t;
  } sample_t;

  typedef struct {
    logic signed [23:0] pos;
    logic signed [23:0] vel;
  } ref_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [23:0] target_move_i;
  logic        [23:0] elapsed_time_i;
  logic               out_valid_o;
  logic signed [23:0] ref_position_o;
  logic signed [23:0] ref_velocity_o;
  logic               cfg_we_i;
  tpg_pkg::reg_idx_e  cfg_idx_i;
  logic        [23:0] cfg_wdata_i;

  sample_t   pending_samples[$];
  ref_word_t expected_words[$];
  logic [23:0] vel_reg;
  logic [23:0] acc_reg;
  bit        hold_off;
  bit        no_gaps;
  int        mismatch_count;
  int        words_checked;
  int        samples_sent;

  trapezoidal_profile_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .target_move_i  (target_move_i),
    .elapsed_time_i (elapsed_time_i),
    .out_valid_o    (out_valid_o),
    .ref_position_o (ref_position_o),
    .ref_velocity_o (ref_velocity_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // floor(a*b / 2^s), held at 2^62
  function automatic longint unsigned scaled_product(longint unsigned a, longint unsigned b,
                                                    int s);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> s;
    if (prod > (128'd1 << 62)) return 64'd1 << 62;
    return prod[63:0];
  endfunction

  // floored square root, one result bit per pass
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // signed output with saturation to the 24 bit field
  function automatic logic [23:0] signed_clip(bit neg, longint unsigned mag);
    if (neg) return (mag >= 64'h800000) ? 24'h800000 : 24'(-mag);
    return (mag > 64'h7FFFFF) ? 24'h7FFFFF : 24'(mag);
  endfunction

  // profile position and velocity for one sample under the current rates
  function automatic ref_word_t profile_point(sample_t s);
    longint unsigned vr, ar, d, tt, p, v, u, ts, t1, tc, dfs;
    bit neg, halt;
    ref_word_t w;
    vr   = (vel_reg == 0) ? 1 : vel_reg;
    ar   = (acc_reg == 0) ? 1 : acc_reg;
    tt   = s.t;
    neg  = s.move[23];
    d    = neg ? (64'h1000000 - {40'd0, s.move}) : {40'd0, s.move};
    p    = 0;
    v    = 0;
    halt = 0;
    if (d * ar < 16 * vr * vr) begin
      // triangle: square root switch time
      ts = floor_sqrt((d << 28) / ar);
      if (tt < ts) begin
        v = (ar * tt) >> 16;
        p = scaled_product(ar * tt, tt, 29);
      end else begin
        u = tt - ts;
        if (u > ts) halt = 1;
        else begin
          v = (ar * (ts - u)) >> 16;
          p = (d >> 1) + scaled_product(ar * u, 2 * ts - u, 29);
        end
      end
    end else begin
      // trapezoid: ramp, cruise, ramp down
      t1  = (vr << 16) / ar;
      tc  = (d << 12) / vr;
      dfs = (8 * vr * vr) / ar;
      if (tt < t1) begin
        v = (ar * tt) >> 16;
        p = scaled_product(ar * tt, tt, 29);
      end else if (tt < tc) begin
        v = vr;
        p = dfs + ((vr * (tt - t1)) >> 12);
      end else begin
        u = tt - tc;
        if (ar * u > (vr << 16)) halt = 1;
        else begin
          v = ((vr << 16) - ar * u) >> 16;
          p = d - dfs + scaled_product(u, (vr << 17) - ar * u, 29);
        end
      end
    end
    // end of profile clamp
    if (halt || p > d) begin
      p = d;
      v = 0;
    end
    w.pos = signed_clip(neg, p);
    w.vel = signed_clip(neg, v);
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("MISMATCH %s at %0t: got %h want %h", what, $time, got, want);
    mismatch_count++;
  endtask

  // driver: presents samples, random gaps, holds until taken
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s;
    if (!rst_ni) begin
      start          <= 1'b0;
      target_move_i  <= '0;
      elapsed_time_i <= '0;
    end else begin
      if (start && !busy) begin
        s.move = target_move_i;
        s.t    = elapsed_time_i;
        expected_words.push_back(profile_point(s));
        samples_sent++;
      end
      if (!start || !busy) begin
        if (pending_samples.size() != 0 && !hold_off &&
            (no_gaps || $urandom_range(99) >= 8)) begin
          s = pending_samples.pop_front();
          start          <= 1'b1;
          target_move_i  <= s.move;
          elapsed_time_i <= s.t;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word against the oldest expectation
  always @(posedge clk_i) begin
    ref_word_t w;
    if (rst_ni && out_valid_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", ref_position_o, 24'd0);
      end else begin
        w = expected_words.pop_front();
        if (ref_position_o !== w.pos) report_mismatch("ref_position", ref_position_o, w.pos);
        if (ref_velocity_o !== w.vel) report_mismatch("ref_velocity", ref_velocity_o, w.vel);
        words_checked++;
      end
    end
  end

  task automatic drain;
    while (pending_samples.size() != 0 || expected_words.size() != 0 || start)
      @(posedge clk_i);
  endtask

  task automatic write_rate(tpg_pkg::reg_idx_e idx, logic [23:0] val);
    while (busy) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tpg_pkg::REG_MAX_VEL) vel_reg = val;
    else acc_reg = val;
  endtask

  task automatic queue_sample(logic [23:0] m, logic [23:0] t);
    sample_t s;
    s.move = m;
    s.t    = t;
    pending_samples.push_back(s);
  endtask

  // random samples: moves of every scale, times near and far
  task automatic queue_random(int n);
    logic [23:0] m, t;
    repeat (n) begin
      case ($urandom_range(3))
        0:       m = 24'($urandom);
        1:       m = 24'($urandom_range(4095)) - 24'd2048;
        2:       m = 24'($urandom) >> $urandom_range(23);
        default: m = ($urandom_range(1) != 0) ? 24'h7FFFFF - 24'($urandom_range(3))
                                              : 24'h800000 + 24'($urandom_range(3));
      endcase
      if ($urandom_range(1)) m = -m;
      if ($urandom_range(3) == 0) t = 24'($urandom);
      else t = 24'($urandom) >> $urandom_range(23);
      queue_sample(m, t);
    end
  endtask

  // stimulus and phases
  initial begin
    logic [23:0] vset[8];
    logic [23:0] aset[8];
    hold_off       = 0;
    no_gaps        = 0;
    mismatch_count = 0;
    words_checked  = 0;
    samples_sent   = 0;
    vel_reg        = tpg_pkg::VelReset;
    acc_reg        = tpg_pkg::AccReset;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = tpg_pkg::REG_MAX_VEL;
    cfg_wdata_i    = '0;
    rst_ni         = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, zero move, segment edges
    queue_sample(24'd0, 24'd0);
    queue_sample(24'd0, 24'hFFFFFF);
    queue_sample(24'h7FFFFF, 24'd0);
    queue_sample(24'h7FFFFF, 24'hFFFFFF);
    queue_sample(24'h800000, 24'd0);
    queue_sample(24'h800000, 24'd65536);
    queue_sample(24'h800000, 24'd200000);
    queue_sample(24'h800000, 24'hFFFFFF);
    queue_sample(24'd1, 24'd1);
    queue_sample(24'hFFFFFF, 24'd1);
    queue_sample(24'h100000, 24'd32768);
    queue_sample(24'h100000, 24'd65536);
    queue_sample(24'h100000, 24'd98304);
    queue_sample(24'hF00000, 24'd131072);
    queue_sample(24'h080000, 24'd30000);
    queue_sample(24'h080000, 24'd50000);
    queue_sample(24'hF80000, 24'd80000);
    queue_sample(24'h400000, 24'd300000);
    queue_sample(24'h400000, 24'd330000);
    queue_sample(24'hC00000, 24'h800000);
    queue_random(180);
    drain();

    // rate settings: extremes, zero used as one, mid and random
    vset = '{24'd1, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd1, 24'd65536, 24'd0, 24'd0};
    aset = '{24'd1, 24'hFFFFFF, 24'd0, 24'd1, 24'hFFFFFF, 24'd131072, 24'd0, 24'd0};
    vset[6] = 24'($urandom); aset[6] = 24'($urandom);
    vset[7] = 24'($urandom_range(2000000)); aset[7] = 24'($urandom_range(2000000));
    for (int ph = 0; ph < 8; ph++) begin
      write_rate(tpg_pkg::REG_MAX_VEL, vset[ph]);
      write_rate(tpg_pkg::REG_MAX_ACC, aset[ph]);
      no_gaps = (ph == 3);
      queue_random(80);
      if (ph == 1) begin
        // sender holds off until the pipeline has emptied
        while (pending_samples.size() != 0 || start) @(posedge clk_i);
        hold_off = 1;
        while (expected_words.size() != 0) @(posedge clk_i);
        hold_off = 0;
      end
      queue_random(90);
      drain();
    end

    repeat (tpg_pkg::Latency + 20) @(posedge clk_i);
    $display("covered %0d samples over 9 rate settings, %0d words checked, %0d mismatches",
             samples_sent, words_checked, mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("trapezoidal_profile_generator_top_tb passed");
    end else begin
      $display("trapezoidal_profile_generator_top_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2ms;
    $display("trapezoidal_profile_generator_top_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
